### rtl/rscb_pkg.sv
// Package for the random six-channel blinker: sizes, function codes and shared types.
// It also holds the random draw helper that every lane uses.
// It depends on nothing else.
package rscb_pkg;

    localparam int CHANNELS  = 6;
    localparam int DRAW_BITS = 10;
    localparam int TIME_W    = 32;
    localparam int DELTA_W   = 20;
    localparam int FUNC_W    = 3;
    localparam int CHAN_W    = 3;
    localparam int DRAWS_W   = 60;
    localparam int PINS_W    = 6;
    localparam int CFG_IDX_W = 8;
    localparam int IN_DATA_W = 152;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = TIME_W + DRAW_BITS;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 3'd0,
        FUNC_START   = 3'd1,
        FUNC_STOP    = 3'd2,
        FUNC_ENABLE  = 3'd3,
        FUNC_DISABLE = 3'd4,
        FUNC_MANUAL  = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_OFF = 8'd0,
        REG_MAX_OFF = 8'd1,
        REG_MIN_ON  = 8'd2,
        REG_MAX_ON  = 8'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] min_off;
        logic [TIME_W-1:0] max_off;
        logic [TIME_W-1:0] min_on;
        logic [TIME_W-1:0] max_on;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic restart;
        logic run;
    } lane_ctrl_t;

    // A value between lo and hi at the fraction frac / 2^DRAW_BITS of the span.
    function automatic logic [TIME_W-1:0] draw_between(
        input logic [TIME_W-1:0]    lo,
        input logic [TIME_W-1:0]    hi,
        input logic [DRAW_BITS-1:0] frac
    );
        logic [TIME_W-1:0] span;
        logic [PROD_W-1:0] prod;
        logic [TIME_W-1:0] off;
        span = (hi >= lo) ? (hi - lo) : (lo - hi);
        prod = PROD_W'(span) * PROD_W'(frac);
        off  = prod[PROD_W-1:DRAW_BITS];
        return (hi >= lo) ? (lo + off) : (lo - off);
    endfunction

endpackage

### rtl/rscb_lane.sv
// One channel of the blinker: its timer, its planned delay and the flip decision.
// It uses the sizes, types and the draw helper of rscb_pkg.
module rscb_lane
    import rscb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           ctrl,
    input  cfg_t                 cfg,
    input  logic                 pin_in,
    input  logic [DELTA_W-1:0]   delta,
    input  logic [DRAW_BITS-1:0] start_frac,
    input  logic [DRAW_BITS-1:0] toggle_frac,
    output logic                 pin_out
);

    logic [TIME_W-1:0] elapsed_reg;
    logic [TIME_W-1:0] elapsed_next;
    logic [TIME_W-1:0] delay_reg;
    logic [TIME_W-1:0] delay_next;
    logic [TIME_W-1:0] el0;
    logic [TIME_W-1:0] dl0;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] t_sat;
    logic [TIME_W-1:0] lo_sel;
    logic [TIME_W-1:0] hi_sel;
    logic [TIME_W-1:0] toggle_delay;
    logic              flip;

    always_comb
    begin
        el0 = ctrl.restart ? '0 : elapsed_reg;
        dl0 = ctrl.restart ? draw_between('0, cfg.max_off, start_frac) : delay_reg;
        sum = {1'b0, el0} + (TIME_W + 1)'(delta);
        t_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        // The pin is about to turn on when it is off now, so the on bounds apply.
        lo_sel = pin_in ? cfg.min_off : cfg.min_on;
        hi_sel = pin_in ? cfg.max_off : cfg.max_on;
        toggle_delay = draw_between(lo_sel, hi_sel, toggle_frac);
        flip = ctrl.run && (t_sat > dl0);
        if (ctrl.run)
        begin
            elapsed_next = flip ? '0 : t_sat;
            delay_next   = flip ? toggle_delay : dl0;
        end
        else
        begin
            elapsed_next = el0;
            delay_next   = dl0;
        end
        pin_out = pin_in ^ flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            delay_reg   <= '0;
        end
        else if (ctrl.tick)
        begin
            elapsed_reg <= elapsed_next;
            delay_reg   <= delay_next;
        end
    end

endmodule

### rtl/rscb_out_buf.sv
// Output register with a skid stage for the result stream.
// It uses the result width from rscb_pkg.
module rscb_out_buf
    import rscb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [OUT_W-1:0] push_data,
    output logic             space,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] main_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             pop;

    assign pop      = main_valid_reg && m_tready;
    assign space    = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

### rtl/random_six_channel_blinker.sv
// Top level of the random six-channel blinker: control flags, the lanes and the result stage.
// It uses rscb_pkg, rscb_lane and rscb_out_buf.
//
// Each request on the input stream is handled in the cycle it is accepted, so a new request
// can enter every clock cycle while the output buffer has space, and its result is registered
// in the output buffer. All six channels update side by side, each with two 32 by 10 bit
// multipliers, one for the start delay and one for the toggle delay. The input stays ready
// while the output holds fewer than two waiting results. Configuration writes are accepted
// at any time and take effect on the next request.
module random_six_channel_blinker
    import rscb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ready_req, delta_us, channel, level, start_draws, toggle_draws, zero fill
    input  logic [IN_DATA_W-1:0] s_tdata,
    // func
    input  logic [FUNC_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pins, running, enabled, any_on, zero fill
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    cfg_t                cfg_reg;
    logic                enabled_reg;
    logic                enabled_next;
    logic                active_reg;
    logic                active_next;
    logic                start_pend_reg;
    logic                start_pend_next;
    logic                stop_pend_reg;
    logic                stop_pend_next;
    logic [CHANNELS-1:0] pins_reg;
    logic [CHANNELS-1:0] pins_next;
    logic [CHANNELS-1:0] pins_mid;
    logic [CHANNELS-1:0] lane_pins;

    logic                accept;
    logic                is_tick;
    logic                space;
    func_t               func;
    logic                ready_req;
    logic [DELTA_W-1:0]  delta_us;
    logic [CHAN_W-1:0]   channel;
    logic                level;
    logic [DRAWS_W-1:0]  start_draws;
    logic [DRAWS_W-1:0]  toggle_draws;
    lane_ctrl_t          lane_ctrl;
    logic [OUT_W-1:0]    result;

    assign func         = func_t'(s_tuser);
    assign ready_req    = s_tdata[0];
    assign delta_us     = s_tdata[20:1];
    assign channel      = s_tdata[23:21];
    assign level        = s_tdata[24];
    assign start_draws  = s_tdata[84:25];
    assign toggle_draws = s_tdata[144:85];

    assign s_tready  = space;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign is_tick   = accept && (func == FUNC_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_off <= 32'd1000000;
            cfg_reg.max_off <= 32'd2000000;
            cfg_reg.min_on  <= 32'd1000000;
            cfg_reg.max_on  <= 32'd2000000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_OFF: cfg_reg.min_off <= cfg_data;
                REG_MAX_OFF: cfg_reg.max_off <= cfg_data;
                REG_MIN_ON:  cfg_reg.min_on  <= cfg_data;
                REG_MAX_ON:  cfg_reg.max_on  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tick sequencing ahead of the lanes: self disable, start service, then stop service.
    logic tk_en;
    logic tk_stop0;
    logic tk_start_go;
    logic tk_stop1;
    logic tk_active1;
    logic tk_stop_go;
    logic [CHANNELS-1:0] tk_pins0;

    always_comb
    begin
        tk_en       = enabled_reg && ready_req;
        tk_stop0    = stop_pend_reg || (enabled_reg && !ready_req);
        tk_pins0    = (enabled_reg && !ready_req) ? '0 : pins_reg;
        tk_start_go = start_pend_reg && !active_reg;
        tk_stop1    = tk_start_go ? 1'b0 : tk_stop0;
        tk_active1  = tk_start_go ? 1'b1 : active_reg;
        tk_stop_go  = tk_stop1 && tk_active1;
        pins_mid    = (tk_start_go || tk_stop_go) ? '0 : tk_pins0;
    end

    assign lane_ctrl.tick    = is_tick;
    assign lane_ctrl.restart = tk_start_go;
    assign lane_ctrl.run     = tk_active1 && !tk_stop_go;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        rscb_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .cfg         (cfg_reg),
            .pin_in      (pins_mid[i]),
            .delta       (delta_us),
            .start_frac  (start_draws[DRAW_BITS*i +: DRAW_BITS]),
            .toggle_frac (toggle_draws[DRAW_BITS*i +: DRAW_BITS]),
            .pin_out     (lane_pins[i])
        );
    end

    always_comb
    begin
        enabled_next    = enabled_reg;
        active_next     = active_reg;
        start_pend_next = start_pend_reg;
        stop_pend_next  = stop_pend_reg;
        pins_next       = pins_reg;
        case (func)
            FUNC_TICK:
            begin
                enabled_next    = tk_en;
                active_next     = tk_active1 && !tk_stop_go;
                start_pend_next = tk_start_go ? 1'b0 : start_pend_reg;
                stop_pend_next  = tk_stop_go ? 1'b0 : tk_stop1;
                pins_next       = tk_en ? lane_pins : '0;
            end
            FUNC_START:
            begin
                start_pend_next = 1'b1;
            end
            FUNC_STOP:
            begin
                stop_pend_next = 1'b1;
            end
            FUNC_ENABLE:
            begin
                if (ready_req)
                begin
                    enabled_next = 1'b1;
                end
            end
            FUNC_DISABLE:
            begin
                stop_pend_next = 1'b1;
                enabled_next   = 1'b0;
                pins_next      = '0;
            end
            FUNC_MANUAL:
            begin
                stop_pend_next = 1'b1;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (channel == CHAN_W'(i))
                    begin
                        pins_next[i] = level;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            active_reg     <= 1'b0;
            start_pend_reg <= 1'b0;
            stop_pend_reg  <= 1'b0;
            pins_reg       <= '0;
        end
        else if (accept)
        begin
            enabled_reg    <= enabled_next;
            active_reg     <= active_next;
            start_pend_reg <= start_pend_next;
            stop_pend_reg  <= stop_pend_next;
            pins_reg       <= pins_next;
        end
    end

    assign result = OUT_W'({(|pins_next), enabled_next, active_next, PINS_W'(pins_next)});

    rscb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_any_on: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[PINS_W+2] == (|m_tdata[PINS_W-1:0])))
        else $error("any_on does not match the pins of the waiting result");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && start_pend_reg && !active_reg) |=> (active_reg && !start_pend_reg))
        else $error("a pending start was not served by the tick");

    a_disable: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_DISABLE)) |=> (!enabled_reg && (pins_reg == '0) && stop_pend_reg))
        else $error("disable did not clear the outputs and the enable flag");

endmodule
